// File: rtl/cpf_pkg.sv
package cpf_pkg;

    localparam int VALUE_W = 32;
    localparam int INDEX_W = 10;
    localparam int EPOCH_W = 4;

    // Tag zero marks a cleared slot, so live epochs run from one to all ones.
    localparam logic [EPOCH_W-1:0] EPOCH_FIRST = EPOCH_W'(1);
    localparam logic [EPOCH_W-1:0] EPOCH_LAST  = '1;

    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic                      last;
    } t_item;

    typedef struct packed {
        logic               found;
        logic [INDEX_W-1:0] first_index;
        logic [INDEX_W-1:0] second_index;
        logic               overflow;
    } t_result;

    // Source of the table read address for the next cycle.
    typedef enum logic [1:0] {
        RD_HOLD,
        RD_COMP,
        RD_VALUE,
        RD_NEXT
    } t_rd_sel;

    typedef struct packed {
        logic    load;
        logic    count;
        logic    mark_over;
        t_rd_sel rd_sel;
        logic    emit_hit;
        logic    insert;
        logic    ins_fail;
        logic    finish;
        logic    clear_step;
    } t_cmd;

    typedef struct packed {
        logic pair_done;
        logic len_full;
        logic last;
        logic comp_ok;
        logic slot_empty;
        logic comp_match;
        logic value_match;
        logic probes_done;
        logic clear_last;
        logic epoch_last;
    } t_stat;

endpackage

// File: rtl/complement_pair_finder.sv
// Each accepted request is looked up by its complement and then stored by its value; a hit
// skips the store, an out-of-range complement skips the lookup, and a request after a hit
// or past the length limit is taken without either. Each collision probes the next slot,
// and a last request adds a finishing step that strobes a not-found result if nothing
// paired. Synchronous active-low reset runs a clearing pass over all TABLE_ENTRIES slots,
// repeated after every fifteenth sequence.
module complement_pair_finder #(
    parameter int TABLE_ENTRIES = 1024,
    parameter int MAX_LENGTH    = 1024
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic signed [31:0] i_cfg_wdata,
    input  logic               start,
    output logic               busy,
    input  cpf_pkg::t_item     i_item,
    output logic               o_strobe,
    output cpf_pkg::t_result   o_result
);
    import cpf_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    cpf_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_last  (i_item.last),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_busy  (busy)
    );

    cpf_datapath #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .MAX_LENGTH    (MAX_LENGTH)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_item      (i_item),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_strobe    (o_strobe),
        .o_result    (o_result)
    );

endmodule

// File: rtl/cpf_ram.sv
module cpf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // One write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: rtl/cpf_datapath.sv
module cpf_datapath #(
    parameter int TABLE_ENTRIES = 1024,
    parameter int MAX_LENGTH    = 1024
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic signed [31:0]   i_cfg_wdata,
    input  cpf_pkg::t_item       i_item,
    input  cpf_pkg::t_cmd        i_cmd,
    output cpf_pkg::t_stat       o_stat,
    output logic                 o_strobe,
    output cpf_pkg::t_result     o_result
);
    import cpf_pkg::*;

    localparam int ADDR_W = $clog2(TABLE_ENTRIES);
    localparam int CNT_W  = $clog2(MAX_LENGTH + 1);
    localparam int POS_W  = $clog2(MAX_LENGTH);
    localparam int DATA_W = EPOCH_W + VALUE_W + POS_W;
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(TABLE_ENTRIES - 1);
    localparam logic [CNT_W-1:0]  COUNT_MAX = CNT_W'(MAX_LENGTH);

    // XOR fold of the key, brought below the table size by one subtraction.
    function automatic logic [ADDR_W-1:0] hash_key(input logic [VALUE_W-1:0] key);
        logic [ADDR_W-1:0] h;
        logic [ADDR_W:0]   d;
        h = '0;
        for (int b = 0; b < VALUE_W; b++) begin
            h[b % ADDR_W] = h[b % ADDR_W] ^ key[b];
        end
        d = {1'b0, h} - (ADDR_W + 1)'(TABLE_ENTRIES);
        return d[ADDR_W] ? h : d[ADDR_W-1:0];
    endfunction

    function automatic logic [INDEX_W-1:0] to_index(input logic [POS_W-1:0] p);
        logic [POS_W+INDEX_W-1:0] w;
        w = (POS_W + INDEX_W)'(p);
        return w[INDEX_W-1:0];
    endfunction

    logic signed [31:0]   r_target, n_target;
    logic [VALUE_W-1:0]   r_value, n_value;
    logic                 r_last, n_last;
    logic [VALUE_W:0]     r_comp, n_comp;
    logic [POS_W-1:0]     r_pos, n_pos;
    logic [CNT_W-1:0]     r_count, n_count;
    logic                 r_pair_done, n_pair_done;
    logic                 r_overflow, n_overflow;
    logic [ADDR_W-1:0]    r_addr;
    logic [ADDR_W-1:0]    r_probe, n_probe;
    logic [ADDR_W-1:0]    r_clr_addr, n_clr_addr;
    logic [EPOCH_W-1:0]   r_epoch, n_epoch;
    logic                 r_strobe, n_strobe;
    t_result              r_result, n_result;

    logic [ADDR_W-1:0]    rd_addr;
    logic                 wr_en;
    logic [ADDR_W-1:0]    wr_addr;
    logic [DATA_W-1:0]    wr_data;
    logic [DATA_W-1:0]    rd_data;
    logic [POS_W-1:0]     rd_pos;
    logic [VALUE_W-1:0]   rd_key;
    logic [EPOCH_W-1:0]   rd_tag;
    logic                 slot_empty;

    // Slot layout: epoch tag, key, position.
    assign rd_pos = rd_data[POS_W-1:0];
    assign rd_key = rd_data[POS_W +: VALUE_W];
    assign rd_tag = rd_data[DATA_W-1 -: EPOCH_W];
    assign slot_empty = (rd_tag != r_epoch);

    // Read address for the next probe.
    always_comb begin
        unique case (i_cmd.rd_sel)
            RD_HOLD:  rd_addr = r_addr;
            RD_COMP:  rd_addr = hash_key(r_comp[VALUE_W-1:0]);
            RD_VALUE: rd_addr = hash_key(r_value);
            RD_NEXT:  rd_addr = (r_addr == LAST_ADDR) ? '0 : r_addr + 1'b1;
            default:  rd_addr = r_addr;
        endcase
    end

    // The clearing pass and an insertion share the single write port.
    assign wr_en   = i_cmd.insert | i_cmd.clear_step;
    assign wr_addr = i_cmd.clear_step ? r_clr_addr : r_addr;
    assign wr_data = i_cmd.clear_step ? '0 : {r_epoch, r_value, r_pos};

    cpf_ram #(
        .WIDTH (DATA_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_table (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // Next-state logic of the datapath registers.
    always_comb begin
        n_target    = r_target;
        n_value     = r_value;
        n_last      = r_last;
        n_comp      = r_comp;
        n_pos       = r_pos;
        n_count     = r_count;
        n_pair_done = r_pair_done;
        n_overflow  = r_overflow;
        n_probe     = r_probe;
        n_clr_addr  = r_clr_addr;
        n_epoch     = r_epoch;
        n_strobe    = 1'b0;
        n_result    = r_result;

        if (i_cfg_we) begin
            n_target = i_cfg_wdata;
        end

        // Capture the request and its exact 33-bit complement.
        if (i_cmd.load) begin
            n_value = i_item.value;
            n_last  = i_item.last;
            n_comp  = {r_target[31], r_target} - {i_item.value[31], i_item.value};
            n_pos   = r_count[POS_W-1:0];
        end
        if (i_cmd.count) begin
            n_count = r_count + 1'b1;
        end
        if (i_cmd.mark_over || i_cmd.ins_fail) begin
            n_overflow = 1'b1;
        end

        // Probe counter restarts with every fresh hash address.
        unique case (i_cmd.rd_sel)
            RD_COMP, RD_VALUE: n_probe = '0;
            RD_NEXT:           n_probe = r_probe + 1'b1;
            default:           n_probe = r_probe;
        endcase

        if (i_cmd.emit_hit) begin
            n_strobe              = 1'b1;
            n_result.found        = 1'b1;
            n_result.first_index  = to_index(rd_pos);
            n_result.second_index = to_index(r_pos);
            n_result.overflow     = r_overflow;
            n_pair_done           = 1'b1;
        end

        // End of sequence: report a miss if nothing paired, then start afresh.
        if (i_cmd.finish) begin
            n_strobe              = ~r_pair_done;
            n_result.found        = 1'b0;
            n_result.first_index  = '0;
            n_result.second_index = '0;
            n_result.overflow     = r_overflow;
            n_count               = '0;
            n_pair_done           = 1'b0;
            n_overflow            = 1'b0;
            if (r_epoch != EPOCH_LAST) begin
                n_epoch = r_epoch + 1'b1;
            end
        end

        if (i_cmd.clear_step) begin
            n_clr_addr = (r_clr_addr == LAST_ADDR) ? '0 : r_clr_addr + 1'b1;
            if (r_clr_addr == LAST_ADDR) begin
                n_epoch = EPOCH_FIRST;
            end
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target    <= '0;
            r_count     <= '0;
            r_pair_done <= 1'b0;
            r_overflow  <= 1'b0;
            r_clr_addr  <= '0;
            r_epoch     <= '0;
            r_strobe    <= 1'b0;
        end else begin
            r_target    <= n_target;
            r_count     <= n_count;
            r_pair_done <= n_pair_done;
            r_overflow  <= n_overflow;
            r_clr_addr  <= n_clr_addr;
            r_epoch     <= n_epoch;
            r_strobe    <= n_strobe;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_value  <= n_value;
        r_last   <= n_last;
        r_comp   <= n_comp;
        r_pos    <= n_pos;
        r_addr   <= rd_addr;
        r_probe  <= n_probe;
        r_result <= n_result;
    end

    assign o_stat.pair_done   = r_pair_done;
    assign o_stat.len_full    = (r_count == COUNT_MAX);
    assign o_stat.last        = r_last;
    assign o_stat.comp_ok     = (r_comp[VALUE_W] == r_comp[VALUE_W-1]);
    assign o_stat.slot_empty  = slot_empty;
    assign o_stat.comp_match  = ~slot_empty && (rd_key == r_comp[VALUE_W-1:0]);
    assign o_stat.value_match = ~slot_empty && (rd_key == r_value);
    assign o_stat.probes_done = (r_probe == LAST_ADDR);
    assign o_stat.clear_last  = (r_clr_addr == LAST_ADDR);
    assign o_stat.epoch_last  = (r_epoch == EPOCH_LAST);

    assign o_strobe = r_strobe;
    assign o_result = r_result;

    a_one_writer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.insert |-> !i_cmd.clear_step)
        else $error("Insertion collides with the clearing pass.");

    a_live_epoch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.insert |-> (r_epoch != '0))
        else $error("Insertion with the reserved cleared-slot tag.");

    a_single_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit_hit |-> !r_pair_done)
        else $error("Second hit reported within one sequence.");

    a_hit_marks_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_strobe && r_result.found) |-> r_pair_done)
        else $error("Hit reported without the pair being recorded.");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= COUNT_MAX)
        else $error("Item count ran past the maximum sequence length.");

endmodule

// File: rtl/cpf_ctrl.sv
module cpf_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  logic           i_last,
    input  cpf_pkg::t_stat i_stat,
    output cpf_pkg::t_cmd  o_cmd,
    output logic           o_busy
);
    import cpf_pkg::*;

    typedef enum logic [5:0] {
        S_CLEAR  = 6'b000001,
        S_IDLE   = 6'b000010,
        S_LREQ   = 6'b000100,
        S_LCHK   = 6'b001000,
        S_ICHK   = 6'b010000,
        S_FINISH = 6'b100000
    } t_state;

    t_state r_state, n_state;
    t_cmd   cmd;

    // Sequencing of lookup, insertion, end of sequence and table clearing.
    always_comb begin
        cmd        = '0;
        cmd.rd_sel = RD_HOLD;
        n_state    = r_state;
        unique case (r_state)
            S_CLEAR: begin
                cmd.clear_step = 1'b1;
                if (i_stat.clear_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_start) begin
                    cmd.load = 1'b1;
                    priority if (i_stat.pair_done) begin
                        if (i_last) begin
                            n_state = S_FINISH;
                        end
                    end else if (i_stat.len_full) begin
                        cmd.mark_over = 1'b1;
                        if (i_last) begin
                            n_state = S_FINISH;
                        end
                    end else begin
                        cmd.count = 1'b1;
                        n_state   = S_LREQ;
                    end
                end
            end
            S_LREQ: begin
                // A complement outside 32 bits cannot match: go straight to insertion.
                if (i_stat.comp_ok) begin
                    cmd.rd_sel = RD_COMP;
                    n_state    = S_LCHK;
                end else begin
                    cmd.rd_sel = RD_VALUE;
                    n_state    = S_ICHK;
                end
            end
            S_LCHK: begin
                priority if (i_stat.comp_match) begin
                    cmd.emit_hit = 1'b1;
                    n_state      = i_stat.last ? S_FINISH : S_IDLE;
                end else if (i_stat.slot_empty || i_stat.probes_done) begin
                    cmd.rd_sel = RD_VALUE;
                    n_state    = S_ICHK;
                end else begin
                    cmd.rd_sel = RD_NEXT;
                end
            end
            S_ICHK: begin
                priority if (i_stat.value_match || i_stat.slot_empty) begin
                    cmd.insert = 1'b1;
                    n_state    = i_stat.last ? S_FINISH : S_IDLE;
                end else if (i_stat.probes_done) begin
                    cmd.ins_fail = 1'b1;
                    n_state      = i_stat.last ? S_FINISH : S_IDLE;
                end else begin
                    cmd.rd_sel = RD_NEXT;
                end
            end
            S_FINISH: begin
                cmd.finish = 1'b1;
                n_state    = i_stat.epoch_last ? S_CLEAR : S_IDLE;
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_cmd  = cmd;
    assign o_busy = (r_state != S_IDLE);

endmodule

// File: dv/complement_pair_finder_tb.sv
module complement_pair_finder_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import cpf_pkg::*;

    localparam int TABLE_ENTRIES = 1024;
    localparam int MAX_LENGTH    = 1024;
    // Long enough to cover a full clearing pass of the table, plus some slack.
    localparam int SETTLE_CYCLES = TABLE_ENTRIES + 64;
    localparam longint VALUE_MIN = -64'sd2147483648;
    localparam longint VALUE_MAX = 64'sd2147483647;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_cfg_we;
    logic signed [31:0] i_cfg_wdata;
    logic               start;
    logic               busy;
    t_item              i_item;
    logic               o_strobe;
    t_result            o_result;

    // Mirror of the block's sequence state.
    logic [31:0] cur_target;
    int unsigned index_of_value [bit [31:0]];
    int unsigned next_index;
    bit          pair_seen;
    bit          values_dropped;

    t_result pair_reports_due [$];
    int      fault_count;
    bit      idle_enabled;

    complement_pair_finder #(
        .TABLE_ENTRIES(TABLE_ENTRIES),
        .MAX_LENGTH   (MAX_LENGTH)
    ) DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata),
        .start      (start),
        .busy       (busy),
        .i_item     (i_item),
        .o_strobe   (o_strobe),
        .o_result   (o_result)
    );

    // Free-running clock, 10 ns period.
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Hard stop. Even if every item probed the whole table twice, the run would stay
    // well below this.
    initial begin
        #100ms;
        $display("complement_pair_finder_tb: done, errors");
        $finish;
    end

    // Forget everything about the current sequence, as the block does after a last item.
    function automatic void clear_sequence_state();
        index_of_value.delete();
        next_index     = 0;
        pair_seen      = 1'b0;
        values_dropped = 1'b0;
    endfunction

    // Work out what an accepted request should produce and queue it.
    function automatic void predict_pair_search(input t_item req);
        t_result   res;
        bit        emit;
        longint    comp;
        bit [31:0] key;
        bit [31:0] val_key;
        emit    = 1'b0;
        res     = '0;
        val_key = req.value;
        if (!pair_seen) begin
            if (next_index >= MAX_LENGTH) begin
                // Past the length limit nothing is looked up or stored.
                values_dropped = 1'b1;
            end else begin
                comp = longint'($signed(cur_target)) - longint'($signed(req.value));
                key  = comp[31:0];
                if (comp >= VALUE_MIN && comp <= VALUE_MAX && index_of_value.exists(key)) begin
                    pair_seen        = 1'b1;
                    res.found        = 1'b1;
                    res.first_index  = index_of_value[key][INDEX_W-1:0];
                    res.second_index = next_index[INDEX_W-1:0];
                    res.overflow     = values_dropped;
                    emit             = 1'b1;
                end else if (index_of_value.exists(val_key)
                             || index_of_value.num() < TABLE_ENTRIES) begin
                    index_of_value[val_key] = next_index;
                end else begin
                    values_dropped = 1'b1;
                end
                next_index++;
            end
            if (req.last && !emit) begin
                res.overflow = values_dropped;
                emit         = 1'b1;
            end
        end
        if (emit) begin
            pair_reports_due = {pair_reports_due, res};
        end
        if (req.last) begin
            clear_sequence_state();
        end
    endfunction

    // Compare every strobed result with the oldest one still due.
    always @(posedge i_clk) begin : check_results
        t_result due;
        if (i_rst_n && o_strobe) begin
            if (pair_reports_due.size() == 0) begin
                $display("%0t: unexpected result: expected none, got %0b/%0d/%0d/%0b",
                         $time, o_result.found, o_result.first_index,
                         o_result.second_index, o_result.overflow);
                fault_count++;
            end else begin
                due = pair_reports_due.pop_front();
                if (o_result.found !== due.found || o_result.first_index !== due.first_index
                    || o_result.second_index !== due.second_index
                    || o_result.overflow !== due.overflow) begin
                    $display("%0t: result mismatch: expected %0b/%0d/%0d/%0b, got %0b/%0d/%0d/%0b",
                             $time, due.found, due.first_index, due.second_index,
                             due.overflow, o_result.found, o_result.first_index,
                             o_result.second_index, o_result.overflow);
                    fault_count++;
                end
            end
        end
    end

    // Present one request and hold it until the block takes it. Start is left high, so
    // the caller either sends again or drops it with stop_requests.
    task automatic send_request(input logic [31:0] value, input logic last);
        t_item req;
        req.value = value;
        req.last  = last;
        if (idle_enabled && $urandom_range(99) < 9) begin
            @(negedge i_clk);
            start <= 1'b0;
            repeat ($urandom_range(5)) @(negedge i_clk);
        end
        @(negedge i_clk);
        start  <= 1'b1;
        i_item <= req;
        do @(posedge i_clk); while (busy);
        predict_pair_search(req);
    endtask

    task automatic stop_requests();
        @(negedge i_clk);
        start <= 1'b0;
    endtask

    // Hold off new requests until every result due has arrived.
    task automatic drain_results();
        stop_requests();
        while (pair_reports_due.size() != 0) @(posedge i_clk);
    endtask

    // Let any trailing work, including a clearing pass, finish before touching the register.
    task automatic settle_block();
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_target(input logic [31:0] target_value);
        settle_block();
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= target_value;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        cur_target = target_value;
    endtask

    // Values biased towards the extremes and small numbers so that pairs turn up.
    function automatic logic [31:0] pick_value();
        case ($urandom_range(15))
            0:       return 32'h8000_0000;
            1:       return 32'h7fff_ffff;
            2:       return 32'h0000_0000;
            3:       return 32'hffff_ffff;
            4, 5:    return $urandom_range(20);
            default: return $urandom();
        endcase
    endfunction

    // Target left at its reset value: extreme values, a hit, ignored items, a lone item.
    task automatic test_default_target();
        // The complement of the most negative value does not fit in 32 bits.
        send_request(32'h8000_0000, 1'b0);
        send_request(32'h0000_0000, 1'b0);
        send_request(32'h0000_0000, 1'b0);
        // After the hit these are ignored; the last one clears the table.
        send_request(32'h0000_0005, 1'b0);
        send_request(32'h0000_0007, 1'b1);
        send_request(32'h0000_0003, 1'b1);
    endtask

    // Largest and smallest targets, a repeated value and a value that could only pair
    // with itself.
    task automatic test_extreme_targets();
        write_target(32'h7fff_ffff);
        send_request(32'hffff_ffff, 1'b0);
        send_request(32'h7fff_ffff, 1'b0);
        // Hit on the last item of the sequence.
        send_request(32'h0000_0000, 1'b1);

        write_target(32'h8000_0000);
        send_request(32'h0000_0001, 1'b0);
        // The repeat moves the stored index of -5 forward.
        send_request(32'hffff_fffb, 1'b0);
        send_request(32'hffff_fffb, 1'b0);
        send_request(32'h8000_0005, 1'b0);
        send_request(32'h0000_0009, 1'b1);

        write_target(32'd14);
        // A value is looked up before it is stored, so alone it finds nothing.
        send_request(32'd7, 1'b1);
        send_request(32'd7, 1'b0);
        send_request(32'd7, 1'b1);
    endtask

    // A sequence longer than the limit: positive values with a zero target never pair,
    // and a matching value beyond the limit must not be looked up.
    task automatic test_overlength();
        logic [31:0] seq_values [$];
        logic [31:0] v;
        write_target(32'h0);
        idle_enabled = 1'b0;
        for (int i = 0; i < MAX_LENGTH + 4; i++) begin
            if (i == MAX_LENGTH + 1) begin
                v = ~seq_values[5] + 32'd1;
            end else if (i % 50 == 49) begin
                v = seq_values[$urandom_range(seq_values.size() - 1)];
            end else begin
                v = $urandom_range(32'h7fff_ffff, 1);
            end
            seq_values = {seq_values, v};
            send_request(v, i == MAX_LENGTH + 3);
        end
        idle_enabled = 1'b1;
    endtask

    // Random sequences over several targets. Most hold a planted pair, some a broken
    // one, the rest are plain noise.
    task automatic test_random_sequences();
        logic [31:0] phase_target;
        logic [31:0] a_val;
        logic [31:0] b_val;
        logic [31:0] v;
        longint      diff;
        int          sent;
        int          len;
        int          pos_a;
        int          pos_b;
        int          mode;
        for (int phase = 0; phase < 5; phase++) begin
            case (phase)
                1:       phase_target = 32'h0;
                2:       phase_target = $urandom_range(24);
                3:       phase_target = 32'h8000_0000 + $urandom_range(8);
                default: phase_target = $urandom();
            endcase
            write_target(phase_target);
            // The first phase runs without any gaps from the sender.
            idle_enabled = (phase != 0);
            sent = 0;
            while (sent < 60) begin
                len  = ($urandom_range(9) == 0) ? $urandom_range(40, 13)
                                                : $urandom_range(12, 1);
                mode = $urandom_range(9);
                a_val = pick_value();
                diff  = longint'($signed(phase_target)) - longint'($signed(a_val));
                if (diff < VALUE_MIN || diff > VALUE_MAX) begin
                    a_val = $signed(phase_target) >>> 1;
                    diff  = longint'($signed(phase_target)) - longint'($signed(a_val));
                end
                b_val = diff[31:0];
                if (mode == 7) begin
                    b_val = b_val + 32'd1;
                end
                pos_a = (len > 1) ? $urandom_range(len - 2) : 0;
                pos_b = (len > 1) ? $urandom_range(len - 1, pos_a + 1) : 0;
                for (int i = 0; i < len; i++) begin
                    if (mode <= 7 && len > 1 && i == pos_a) begin
                        v = a_val;
                    end else if (mode <= 7 && len > 1 && i == pos_b) begin
                        v = b_val;
                    end else if (mode <= 7 && $urandom_range(3) == 0) begin
                        v = a_val;
                    end else begin
                        v = pick_value();
                    end
                    send_request(v, i == len - 1);
                end
                sent += len;
                if ($urandom_range(49) == 0) begin
                    drain_results();
                end
            end
        end
    endtask

    initial begin
        i_rst_n      = 1'b0;
        i_cfg_we     = 1'b0;
        i_cfg_wdata  = '0;
        start        = 1'b0;
        i_item       = '0;
        fault_count  = 0;
        idle_enabled = 1'b1;
        cur_target   = '0;
        clear_sequence_state();

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_default_target();
        test_extreme_targets();
        test_overlength();
        test_random_sequences();

        settle_block();
        if (fault_count == 0) begin
            $display("complement_pair_finder_tb: done, clean");
        end else begin
            $display("complement_pair_finder_tb: done, errors");
        end
        $finish;
    end

endmodule

// File: files.f
rtl/cpf_pkg.sv
rtl/cpf_ram.sv
rtl/cpf_datapath.sv
rtl/cpf_ctrl.sv
rtl/complement_pair_finder.sv
dv/complement_pair_finder_tb.sv
